FILE: src/atok_pkg.sv
// Shared types, codes and the character classifier for the arithmetic expression tokenizer.
// Used by atok_front, atok_rsp_queue, atok_back and arith_expr_tokenizer; depends on nothing.
package atok_pkg;

   localparam int POS_BITS_DEFAULT = 16;

   // Queue depths; both must be powers of two.
   localparam int LINK_DEPTH = 4;
   localparam int RSP_DEPTH  = 4;

   // Character classes decided by the front end.
   localparam logic [2:0] CLS_WS    = 3'd0;
   localparam logic [2:0] CLS_DIGIT = 3'd1;
   localparam logic [2:0] CLS_SOP   = 3'd2;
   localparam logic [2:0] CLS_HOLD  = 3'd3;
   localparam logic [2:0] CLS_OTHER = 3'd4;
   localparam logic [2:0] CLS_END   = 3'd5;

   // Token kinds.
   localparam logic [1:0] TK_OP  = 2'd0;
   localparam logic [1:0] TK_NUM = 2'd1;
   localparam logic [1:0] TK_END = 2'd2;
   localparam logic [1:0] TK_ERR = 2'd3;

   // Operator codes.
   localparam logic [3:0] OP_PLUS  = 4'd0;
   localparam logic [3:0] OP_MINUS = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_DIV   = 4'd3;
   localparam logic [3:0] OP_LPAR  = 4'd4;
   localparam logic [3:0] OP_RPAR  = 4'd5;
   localparam logic [3:0] OP_LT    = 4'd6;
   localparam logic [3:0] OP_GT    = 4'd7;
   localparam logic [3:0] OP_EQ    = 4'd8;
   localparam logic [3:0] OP_NE    = 4'd9;
   localparam logic [3:0] OP_LE    = 4'd10;
   localparam logic [3:0] OP_GE    = 4'd11;

   // Characters that are held until the next one decides.
   localparam logic [1:0] HOLD_LT   = 2'd0;
   localparam logic [1:0] HOLD_GT   = 2'd1;
   localparam logic [1:0] HOLD_EQ   = 2'd2;
   localparam logic [1:0] HOLD_BANG = 2'd3;

   localparam logic [62:0] NUM_MAX = {63{1'b1}};
   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   typedef struct packed {
      logic [2:0] cls;
      logic [3:0] code;   // digit value, operator code or held character
   } item_class_type;

   typedef struct packed {
      logic [1:0]  token_kind;
      logic [3:0]  operator_code;
      logic [62:0] number_value;
      logic [15:0] start_position;
      logic [15:0] token_length;
      logic        last_of_run;
   } token_type;

   function automatic item_class_type classify(input logic kind, input logic [7:0] c);
      item_class_type r;
      r.cls  = CLS_OTHER;
      r.code = '0;
      if (kind) begin
         r.cls = CLS_END;
      end else begin
         case (c) inside
            [8'd9:8'd13], 8'd32: r.cls = CLS_WS;
            [8'h30:8'h39]: begin
               r.cls  = CLS_DIGIT;
               r.code = c[3:0];
            end
            "+": begin r.cls = CLS_SOP; r.code = OP_PLUS;  end
            "-": begin r.cls = CLS_SOP; r.code = OP_MINUS; end
            "*": begin r.cls = CLS_SOP; r.code = OP_MUL;   end
            "/": begin r.cls = CLS_SOP; r.code = OP_DIV;   end
            "(": begin r.cls = CLS_SOP; r.code = OP_LPAR;  end
            ")": begin r.cls = CLS_SOP; r.code = OP_RPAR;  end
            "<": begin r.cls = CLS_HOLD; r.code = {2'b00, HOLD_LT};   end
            ">": begin r.cls = CLS_HOLD; r.code = {2'b00, HOLD_GT};   end
            "=": begin r.cls = CLS_HOLD; r.code = {2'b00, HOLD_EQ};   end
            "!": begin r.cls = CLS_HOLD; r.code = {2'b00, HOLD_BANG}; end
            default: r.cls = CLS_OTHER;
         endcase
      end
      return r;
   endfunction

   // Two-character operator formed by a held character and a following '='.
   function automatic logic [3:0] pair_op(input logic [1:0] held);
      logic [3:0] r;
      case (held)
         HOLD_LT: r = OP_LE;
         HOLD_GT: r = OP_GE;
         HOLD_EQ: r = OP_EQ;
         default: r = OP_NE;
      endcase
      return r;
   endfunction

   function automatic token_type make_token(input logic [1:0] kind, input logic [3:0] op,
                                            input logic [62:0] value, input logic [15:0] start,
                                            input logic [15:0] len);
      token_type t;
      t.token_kind     = kind;
      t.operator_code  = op;
      t.number_value   = value;
      t.start_position = start;
      t.token_length   = len;
      t.last_of_run    = 1'b0;
      return t;
   endfunction

endpackage

FILE: src/atok_front.sv
// Front end: accepts characters, classifies them, stamps positions and queues them.
// Depends on atok_pkg.
module atok_front #(
   parameter int POSITION_BITS = atok_pkg::POS_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic                       req_kind,
   input  logic [7:0]                 req_char_byte,
   output logic                       link_valid,
   output atok_pkg::item_class_type   link_item,
   output logic [POSITION_BITS-1:0]   link_pos,
   input  logic                       link_take
);
   import atok_pkg::*;

   localparam int PTR_BITS = $clog2(LINK_DEPTH);
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [PTR_BITS:0] LINK_FULL = (PTR_BITS+1)'(LINK_DEPTH);

   item_class_type             item_q_ff [LINK_DEPTH];
   logic [POSITION_BITS-1:0]   stamp_q_ff [LINK_DEPTH];
   logic [PTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]          count_ff, count_in;
   logic [POSITION_BITS-1:0]   pos_ff, pos_in;
   logic                       accept;

   assign full       = (count_ff == LINK_FULL);
   assign accept     = push && !full;
   assign link_valid = (count_ff != '0);
   assign link_item  = item_q_ff[rd_ptr_ff];
   assign link_pos   = stamp_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = link_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({accept, link_take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
      // The position of the next character; end of input starts a new string.
      pos_in = pos_ff;
      if (accept) begin
         if (req_kind) begin
            pos_in = '0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         pos_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_q_ff[wr_ptr_ff]  <= classify(req_kind, req_char_byte);
         stamp_q_ff[wr_ptr_ff] <= pos_ff;
      end
   end

endmodule

FILE: src/atok_rsp_queue.sv
// Result queue: takes up to two tokens per cycle, hands out one per cycle.
// Depends on atok_pkg.
module atok_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           wr_count,
   input  atok_pkg::token_type  wr_tok0,
   input  atok_pkg::token_type  wr_tok1,
   output logic                 room,
   output logic                 empty,
   input  logic                 pop,
   output atok_pkg::token_type  head
);
   import atok_pkg::*;

   localparam int PTR_BITS = $clog2(RSP_DEPTH);
   localparam logic [PTR_BITS:0] ROOM_LIMIT = (PTR_BITS+1)'(RSP_DEPTH - 2);

   token_type            tok_q_ff [RSP_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]    count_ff, count_in;
   logic                 take;

   assign empty = (count_ff == '0);
   assign take  = pop && !empty;
   assign room  = (count_ff <= ROOM_LIMIT);
   assign head  = tok_q_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff + {{(PTR_BITS-1){1'b0}}, wr_count} - {{PTR_BITS{1'b0}}, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(wr_count);
         rd_ptr_ff <= rd_ptr_ff + {{(PTR_BITS-1){1'b0}}, take};
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) begin
         tok_q_ff[wr_ptr_ff] <= wr_tok0;
      end
      if (wr_count == 2'd2) begin
         tok_q_ff[wr_ptr_ff + 1'b1] <= wr_tok1;
      end
   end

endmodule

FILE: src/atok_back.sv
// Back end: the scanner state machine that turns classified characters into tokens.
// Depends on atok_pkg and atok_rsp_queue.
module atok_back #(
   parameter int POSITION_BITS = atok_pkg::POS_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       link_valid,
   input  atok_pkg::item_class_type   link_item,
   input  logic [POSITION_BITS-1:0]   link_pos,
   output logic                       link_take,
   output logic                       empty,
   input  logic                       pop,
   output atok_pkg::token_type        rsp_head
);
   import atok_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HELD = 2'd1;
   localparam logic [1:0] PH_NUM  = 2'd2;
   localparam logic [1:0] PH_ERR  = 2'd3;
   localparam logic [POSITION_BITS+15:0] LEN_MAX_EXT = {{POSITION_BITS{1'b0}}, LEN_MAX};

   logic [1:0]                 phase_ff, phase_in;
   logic [1:0]                 hold_ff, hold_in;
   logic [62:0]                acc_ff, acc_in;
   logic [POSITION_BITS-1:0]   start_ff, start_in;

   logic                       room;
   logic [1:0]                 wr_count, tok_count;
   token_type                  tok0, tok1;
   token_type                  pre_tok, second_tok, num_tok, held_tok, end_tok;
   logic                       pre_v, second_v, do_start;

   logic [POSITION_BITS+15:0]  pos_ext, start_ext, diff_ext;
   logic [15:0]                pos16, start16, num_len;
   logic [66:0]                acc_wide;
   logic [62:0]                acc_next;

   atok_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_count (wr_count),
      .wr_tok0  (tok0),
      .wr_tok1  (tok1),
      .room     (room),
      .empty    (empty),
      .pop      (pop),
      .head     (rsp_head)
   );

   assign link_take = link_valid && room;
   assign wr_count  = link_take ? tok_count : 2'd0;

   // Positions leave the block as their low 16 bits; lengths saturate.
   assign pos_ext   = {16'b0, link_pos};
   assign start_ext = {16'b0, start_ff};
   assign diff_ext  = {16'b0, link_pos - start_ff};
   assign pos16     = pos_ext[15:0];
   assign start16   = start_ext[15:0];
   assign num_len   = (diff_ext > LEN_MAX_EXT) ? LEN_MAX : diff_ext[15:0];

   // acc * 10 + digit; anything past 63 bits saturates.
   assign acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + {63'b0, link_item.code};
   assign acc_next = (acc_wide[66:63] != 4'b0) ? NUM_MAX : acc_wide[62:0];

   always_comb begin
      num_tok = make_token(TK_NUM, OP_PLUS, acc_ff, start16, num_len);
      end_tok = make_token(TK_END, OP_PLUS, '0, pos16, 16'd0);
      if (hold_ff == HOLD_LT || hold_ff == HOLD_GT) begin
         held_tok = make_token(TK_OP, OP_LT + {2'b00, hold_ff}, '0, start16, 16'd1);
      end else begin
         held_tok = make_token(TK_ERR, OP_PLUS, '0, start16, 16'd0);
      end

      phase_in   = phase_ff;
      hold_in    = hold_ff;
      acc_in     = acc_ff;
      start_in   = start_ff;
      pre_tok    = '0;
      pre_v      = 1'b0;
      second_tok = '0;
      second_v   = 1'b0;
      do_start   = 1'b0;

      if (link_item.cls == CLS_END) begin
         if (phase_ff == PH_HELD) begin
            pre_tok = held_tok;
            pre_v   = 1'b1;
         end else if (phase_ff == PH_NUM) begin
            pre_tok = num_tok;
            pre_v   = 1'b1;
         end
         second_tok = end_tok;
         second_v   = 1'b1;
         phase_in   = PH_IDLE;
         hold_in    = HOLD_LT;
      end else begin
         case (phase_ff)
            PH_ERR: begin
            end
            PH_HELD: begin
               if (link_item.cls == CLS_HOLD && link_item.code[1:0] == HOLD_EQ) begin
                  pre_tok  = make_token(TK_OP, pair_op(hold_ff), '0, start16, 16'd2);
                  pre_v    = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  pre_tok = held_tok;
                  pre_v   = 1'b1;
                  // A lone '=' or '!' is an error; a lone '<' or '>' lets the
                  // new character start over.
                  if (hold_ff == HOLD_LT || hold_ff == HOLD_GT) begin
                     do_start = 1'b1;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
            end
            PH_NUM: begin
               if (link_item.cls == CLS_DIGIT) begin
                  acc_in = acc_next;
               end else begin
                  pre_tok  = num_tok;
                  pre_v    = 1'b1;
                  do_start = 1'b1;
               end
            end
            default: do_start = 1'b1;
         endcase

         if (do_start) begin
            phase_in = PH_IDLE;
            case (link_item.cls)
               CLS_WS: begin
               end
               CLS_HOLD: begin
                  phase_in = PH_HELD;
                  hold_in  = link_item.code[1:0];
                  start_in = link_pos;
               end
               CLS_SOP: begin
                  second_tok = make_token(TK_OP, link_item.code, '0, pos16, 16'd1);
                  second_v   = 1'b1;
               end
               CLS_DIGIT: begin
                  phase_in = PH_NUM;
                  acc_in   = {59'b0, link_item.code};
                  start_in = link_pos;
               end
               default: begin
                  second_tok = make_token(TK_ERR, OP_PLUS, '0, pos16, 16'd0);
                  second_v   = 1'b1;
                  phase_in   = PH_ERR;
               end
            endcase
         end
      end

      // Pack the results to the front and mark the last one.
      if (pre_v) begin
         tok0      = pre_tok;
         tok1      = second_tok;
         tok_count = second_v ? 2'd2 : 2'd1;
      end else begin
         tok0      = second_tok;
         tok1      = '0;
         tok_count = second_v ? 2'd1 : 2'd0;
      end
      if (tok_count == 2'd2) begin
         tok1.last_of_run = 1'b1;
      end else begin
         tok0.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hold_ff  <= HOLD_LT;
      end else if (link_take) begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (link_take) begin
         acc_ff   <= acc_in;
         start_ff <= start_in;
      end
   end

endmodule

FILE: src/arith_expr_tokenizer.sv
// Top level of the arithmetic expression tokenizer: front end, scanner and result queue.
// Depends on atok_pkg, atok_front and atok_back.
//
//   channel   ports                                   handshake
//   input     req_kind, req_char_byte                 push / full
//   result    rsp_token_kind .. rsp_last_of_run       pop / empty
//
// One item is accepted per cycle while the four-entry input queue has space.
// The scanner retires one item per cycle whenever the result queue has two free
// slots; an item gives zero, one or two results. An item is registered in the input
// queue, its results in the result queue, whose head drives the result ports.
// Reset is synchronous and empties both queues; no clearing pass.
module arith_expr_tokenizer #(
   parameter int POSITION_BITS = atok_pkg::POS_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_kind,
   input  logic [7:0]  req_char_byte,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_token_kind,
   output logic [3:0]  rsp_operator_code,
   output logic [62:0] rsp_number_value,
   output logic [15:0] rsp_start_position,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);
   import atok_pkg::*;

   logic                       link_valid;
   logic                       link_take;
   item_class_type             link_item;
   logic [POSITION_BITS-1:0]   link_pos;
   token_type                  rsp_head;

   atok_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_kind      (req_kind),
      .req_char_byte (req_char_byte),
      .link_valid    (link_valid),
      .link_item     (link_item),
      .link_pos      (link_pos),
      .link_take     (link_take)
   );

   atok_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .link_valid (link_valid),
      .link_item  (link_item),
      .link_pos   (link_pos),
      .link_take  (link_take),
      .empty      (empty),
      .pop        (pop),
      .rsp_head   (rsp_head)
   );

   assign rsp_token_kind     = rsp_head.token_kind;
   assign rsp_operator_code  = rsp_head.operator_code;
   assign rsp_number_value   = rsp_head.number_value;
   assign rsp_start_position = rsp_head.start_position;
   assign rsp_token_length   = rsp_head.token_length;
   assign rsp_last_of_run    = rsp_head.last_of_run;

`ifndef SYNTHESIS
   // The scanner never takes from an empty input queue.
   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      link_take |-> link_valid)
      else $error("scanner took an item from an empty queue");

   // End of input always leaves at least the end token behind.
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (link_take && link_item.cls == CLS_END) |=> !empty)
      else $error("end of input produced no result");

   // The end token closes its run.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_token_kind == TK_END) |-> rsp_last_of_run)
      else $error("end token not marked last");

   // Only number tokens carry a value.
   a_value_only_numbers: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_token_kind != TK_NUM) |-> (rsp_number_value == '0))
      else $error("non-number token carries a value");
`endif

endmodule
